// ===== hw/rtl/refraction_vector_top_defines.svh =====
// ---------------------------------------------------------------------------
// refraction_vector_top_defines
// assertion macros used by refraction_vector_top
// ---------------------------------------------------------------------------
`ifndef REFRACTION_VECTOR_TOP_DEFINES_SVH
`define REFRACTION_VECTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define REFV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define REFV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define REFV_ASSERT(lbl, prop, msg)
`define REFV_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/refv_pkg.sv =====
// ---------------------------------------------------------------------------
// refv_pkg
// constants and sideband types of the refraction vector pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package refv_pkg;

  localparam int DIV_STEPS    = 25;
  localparam int SQRT_STEPS   = 15;
  localparam int FRONT_STAGES = 2;
  localparam int MID_STAGES   = 5;
  localparam int BACK_STAGES  = 3;
  localparam int PIPE_LAT     = FRONT_STAGES + DIV_STEPS + MID_STAGES + SQRT_STEPS
                                + BACK_STAGES;

  localparam logic [15:0] IOR_MIN      = 16'd4096;
  // partial remainder of 2^36 once the quotient bits above bit 24 are done
  localparam logic [15:0] DIV_REM_INIT = 16'd2048;

  typedef logic signed [15:0] comp_t;
  typedef logic signed [16:0] ncomp_t;

  typedef struct packed {
    comp_t              ix;
    comp_t              iy;
    comp_t              iz;
    comp_t              nx;
    comp_t              ny;
    comp_t              nz;
    logic signed [29:0] cosv;
    logic [15:0]        ior;
  } refv_dside_t;

  typedef struct packed {
    comp_t       ix;
    comp_t       iy;
    comp_t       iz;
    ncomp_t      nx;
    ncomp_t      ny;
    ncomp_t      nz;
    logic [27:0] eta;
    logic [32:0] etacos;
    logic        tir;
  } refv_sside_t;

endpackage

// ===== hw/rtl/refv_div.sv =====
// ---------------------------------------------------------------------------
// refv_div
// pipelined restoring divider, one quotient bit per stage: floor(2^36 / ior)
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module refv_div import refv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  refv_dside_t in_side,
  output logic        out_valid,
  output logic [24:0] out_quot,
  output refv_dside_t out_side
);

  logic [DIV_STEPS-1:0] vld_r;
  logic [15:0]          rem_r  [DIV_STEPS];
  logic [24:0]          quot_r [DIV_STEPS];
  refv_dside_t          side_r [DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    logic        vld_in;
    logic [15:0] rem_in;
    logic [24:0] quot_in;
    refv_dside_t side_in;
    logic [16:0] dbl;
    logic [15:0] rem_nxt;
    logic [24:0] quot_nxt;

    if (g == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = DIV_REM_INIT;
      assign quot_in = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign vld_in  = vld_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign quot_in = quot_r[g-1];
      assign side_in = side_r[g-1];
    end

    always_comb begin
      dbl = {rem_in, 1'b0};
      if (dbl >= {1'b0, side_in.ior}) begin
        rem_nxt  = 16'(dbl - {1'b0, side_in.ior});
        quot_nxt = {quot_in[23:0], 1'b1};
      end else begin
        rem_nxt  = dbl[15:0];
        quot_nxt = {quot_in[23:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_in;
      end
      rem_r[g]  <= rem_nxt;
      quot_r[g] <= quot_nxt;
      side_r[g] <= side_in;
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_quot  = quot_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];

endmodule

// ===== hw/rtl/refv_sqrt.sv =====
// ---------------------------------------------------------------------------
// refv_sqrt
// pipelined integer square root, one root bit per stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module refv_sqrt import refv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [29:0] in_rad,
  input  refv_sside_t in_side,
  output logic        out_valid,
  output logic [14:0] out_root,
  output refv_sside_t out_side
);

  logic [SQRT_STEPS-1:0] vld_r;
  logic [29:0]           rad_r  [SQRT_STEPS];
  logic [16:0]           rem_r  [SQRT_STEPS];
  logic [14:0]           root_r [SQRT_STEPS];
  refv_sside_t           side_r [SQRT_STEPS];

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    logic        vld_in;
    logic [29:0] rad_in;
    logic [16:0] rem_in;
    logic [14:0] root_in;
    refv_sside_t side_in;
    logic [18:0] cat;
    logic [18:0] trial;
    logic [16:0] rem_nxt;
    logic [14:0] root_nxt;

    if (g == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign vld_in  = vld_r[g-1];
      assign rad_in  = rad_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign side_in = side_r[g-1];
    end

    always_comb begin
      cat   = {rem_in, rad_in[29:28]};
      trial = {2'b00, root_in, 2'b01};
      if (cat >= trial) begin
        rem_nxt  = 17'(cat - trial);
        root_nxt = {root_in[13:0], 1'b1};
      end else begin
        rem_nxt  = cat[16:0];
        root_nxt = {root_in[13:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_in;
      end
      rad_r[g]  <= {rad_in[27:0], 2'b00};
      rem_r[g]  <= rem_nxt;
      root_r[g] <= root_nxt;
      side_r[g] <= side_in;
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1];
  assign out_side  = side_r[SQRT_STEPS-1];

endmodule

// ===== hw/rtl/refraction_vector_top.sv =====
// ---------------------------------------------------------------------------
// refraction_vector_top
// snell refraction of an incident direction about a surface normal
// ---------------------------------------------------------------------------
// One vector is taken on every cycle that start is high and busy is low;
// busy is high only while reset is held. Each vector gives exactly one
// result, strobed by out_valid for one cycle, once it has passed through the
// pipeline (2 dot-product stages, 25 reciprocal divider stages, 5 multiply
// stages, 15 square root stages, 3 output stages). The result cannot be held off,
// so the receiver must take it in that cycle.
`timescale 1ns / 1ps
`include "refraction_vector_top_defines.svh"
module refraction_vector_top import refv_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  in_incident_x,
  input  logic signed [15:0]  in_incident_y,
  input  logic signed [15:0]  in_incident_z,
  input  logic signed [15:0]  in_normal_x,
  input  logic signed [15:0]  in_normal_y,
  input  logic signed [15:0]  in_normal_z,
  input  logic [15:0]         in_index_of_refraction,
  output logic                out_valid,
  output logic signed [23:0]  out_refracted_x,
  output logic signed [23:0]  out_refracted_y,
  output logic signed [23:0]  out_refracted_z,
  output logic                out_total_reflection
);

  localparam logic signed [33:0] DOT_MAX = 34'sd268435456;
  localparam logic signed [33:0] DOT_MIN = -34'sd268435456;
  localparam logic signed [29:0] COS_MAX = 30'sd268435456;
  localparam logic signed [29:0] COS_MIN = -30'sd268435456;
  localparam logic [28:0]        ONE_U28 = 29'd268435456;
  localparam logic signed [39:0] ONE_K   = 40'sd268435456;
  localparam logic signed [25:0] SAT_MAX = 26'sd8388607;
  localparam logic signed [25:0] SAT_MIN = -26'sd8388608;

  function automatic logic signed [23:0] sat24(input logic signed [53:0] v);
    logic signed [53:0] rnd;
    logic signed [25:0] sh;
    rnd = v + 54'sd134217728;
    sh  = 26'(rnd >>> 28);
    if (sh > SAT_MAX) begin
      return SAT_MAX[23:0];
    end else if (sh < SAT_MIN) begin
      return SAT_MIN[23:0];
    end
    return sh[23:0];
  endfunction

  assign busy = !rst_n;

  // stage 1: capture and component products
  logic               v1_r;
  comp_t              ix1_r, iy1_r, iz1_r, nx1_r, ny1_r, nz1_r;
  logic signed [31:0] p0_r, p1_r, p2_r;
  logic [15:0]        ior1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    ix1_r  <= in_incident_x;
    iy1_r  <= in_incident_y;
    iz1_r  <= in_incident_z;
    nx1_r  <= in_normal_x;
    ny1_r  <= in_normal_y;
    nz1_r  <= in_normal_z;
    p0_r   <= in_incident_x * in_normal_x;
    p1_r   <= in_incident_y * in_normal_y;
    p2_r   <= in_incident_z * in_normal_z;
    ior1_r <= (in_index_of_refraction < IOR_MIN) ? IOR_MIN : in_index_of_refraction;
  end

  // stage 2: dot product, clamped to [-1, 1]
  logic               v2_r;
  refv_dside_t        dside2_r;
  logic signed [33:0] dot;
  logic signed [29:0] cos_cl;

  always_comb begin
    dot = 34'(p0_r) + 34'(p1_r) + 34'(p2_r);
    if (dot > DOT_MAX) begin
      cos_cl = COS_MAX;
    end else if (dot < DOT_MIN) begin
      cos_cl = COS_MIN;
    end else begin
      cos_cl = dot[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    dside2_r <= '{ix: ix1_r, iy: iy1_r, iz: iz1_r, nx: nx1_r, ny: ny1_r, nz: nz1_r,
                  cosv: cos_cl, ior: ior1_r};
  end

  logic        vd;
  logic [24:0] quot;
  refv_dside_t dside;

  refv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v2_r),
    .in_side  (dside2_r),
    .out_valid(vd),
    .out_quot (quot),
    .out_side (dside)
  );

  // stage 3: entering or leaving, pick eta and the normal's sign
  logic               v3_r;
  comp_t              ix3_r, iy3_r, iz3_r;
  ncomp_t             nx3_r, ny3_r, nz3_r;
  logic [27:0]        eta3_r;
  logic [28:0]        cosa3_r;
  logic               enter;
  logic signed [29:0] cos_neg;

  assign enter   = dside.cosv < 30'sd0;
  assign cos_neg = -dside.cosv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= vd;
    end
    ix3_r   <= dside.ix;
    iy3_r   <= dside.iy;
    iz3_r   <= dside.iz;
    nx3_r   <= enter ? 17'(dside.nx) : -17'(dside.nx);
    ny3_r   <= enter ? 17'(dside.ny) : -17'(dside.ny);
    nz3_r   <= enter ? 17'(dside.nz) : -17'(dside.nz);
    eta3_r  <= enter ? {3'b000, quot} : {dside.ior, 12'h000};
    cosa3_r <= enter ? cos_neg[28:0] : dside.cosv[28:0];
  end

  // stage 4: squares and eta*cos
  logic        v4_r;
  comp_t       ix4_r, iy4_r, iz4_r;
  ncomp_t      nx4_r, ny4_r, nz4_r;
  logic [27:0] eta4_r;
  logic [55:0] eta2p4_r;
  logic [57:0] cos2p4_r;
  logic [56:0] etacosp4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    ix4_r      <= ix3_r;
    iy4_r      <= iy3_r;
    iz4_r      <= iz3_r;
    nx4_r      <= nx3_r;
    ny4_r      <= ny3_r;
    nz4_r      <= nz3_r;
    eta4_r     <= eta3_r;
    eta2p4_r   <= eta3_r * eta3_r;
    cos2p4_r   <= cosa3_r * cosa3_r;
    etacosp4_r <= 57'(eta3_r * cosa3_r);
  end

  // stage 5: rounding, s = 1 - cos^2
  logic        v5_r;
  comp_t       ix5_r, iy5_r, iz5_r;
  ncomp_t      nx5_r, ny5_r, nz5_r;
  logic [27:0] eta5_r;
  logic [32:0] eta2_5_r;
  logic [28:0] s5_r;
  logic [32:0] etacos5_r;
  logic [28:0] cos2;

  assign cos2 = 29'((cos2p4_r + 58'd134217728) >> 28);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    ix5_r     <= ix4_r;
    iy5_r     <= iy4_r;
    iz5_r     <= iz4_r;
    nx5_r     <= nx4_r;
    ny5_r     <= ny4_r;
    nz5_r     <= nz4_r;
    eta5_r    <= eta4_r;
    eta2_5_r  <= 33'((eta2p4_r + 56'd8388608) >> 24);
    s5_r      <= ONE_U28 - cos2;
    etacos5_r <= 33'((etacosp4_r + 57'd8388608) >> 24);
  end

  // stage 6: eta^2 * s
  logic        v6_r;
  refv_sside_t sside6_r;
  logic [61:0] esp6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    sside6_r <= '{ix: ix5_r, iy: iy5_r, iz: iz5_r, nx: nx5_r, ny: ny5_r, nz: nz5_r,
                  eta: eta5_r, etacos: etacos5_r, tir: 1'b0};
    esp6_r   <= eta2_5_r * s5_r;
  end

  // stage 7: k and the total reflection test
  logic               v7_r;
  refv_sside_t        sside7_r;
  refv_sside_t        sside7_nxt;
  logic [28:0]        krad7_r;
  logic [37:0]        es;
  logic signed [39:0] kval;
  logic               tir;

  assign es   = 38'((esp6_r + 62'd8388608) >> 24);
  assign kval = ONE_K - $signed({2'b00, es});
  assign tir  = kval < 40'sd0;

  always_comb begin
    sside7_nxt     = sside6_r;
    sside7_nxt.tir = tir;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    sside7_r <= sside7_nxt;
    krad7_r  <= tir ? '0 : kval[28:0];
  end

  logic        vs;
  logic [14:0] root;
  refv_sside_t sside;

  refv_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v7_r),
    .in_rad   ({1'b0, krad7_r}),
    .in_side  (sside7_r),
    .out_valid(vs),
    .out_root (root),
    .out_side (sside)
  );

  // stage 8: t = eta*cos - sqrt(k), incident times eta
  logic               v8_r;
  logic               tir8_r;
  ncomp_t             nx8_r, ny8_r, nz8_r;
  logic signed [34:0] t8_r;
  logic signed [44:0] ax8_r, ay8_r, az8_r;
  logic signed [28:0] eta_s;

  assign eta_s = $signed({1'b0, sside.eta});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= vs;
    end
    tir8_r <= sside.tir;
    nx8_r  <= sside.nx;
    ny8_r  <= sside.ny;
    nz8_r  <= sside.nz;
    t8_r   <= $signed({2'b00, sside.etacos}) - $signed({6'b000000, root, 14'h0000});
    ax8_r  <= sside.ix * eta_s;
    ay8_r  <= sside.iy * eta_s;
    az8_r  <= sside.iz * eta_s;
  end

  // stage 9: normal times t
  logic               v9_r;
  logic               tir9_r;
  logic signed [44:0] ax9_r, ay9_r, az9_r;
  logic signed [51:0] bx9_r, by9_r, bz9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= v8_r;
    end
    tir9_r <= tir8_r;
    ax9_r  <= ax8_r;
    ay9_r  <= ay8_r;
    az9_r  <= az8_r;
    bx9_r  <= nx8_r * t8_r;
    by9_r  <= ny8_r * t8_r;
    bz9_r  <= nz8_r * t8_r;
  end

  // stage 10: sum, round to Q.14, saturate
  logic               out_valid_r;
  logic               out_tir_r;
  logic signed [23:0] out_x_r, out_y_r, out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v9_r;
    end
    out_tir_r <= tir9_r;
    out_x_r   <= tir9_r ? '0 : sat24((54'(ax9_r) <<< 4) + 54'(bx9_r));
    out_y_r   <= tir9_r ? '0 : sat24((54'(ay9_r) <<< 4) + 54'(by9_r));
    out_z_r   <= tir9_r ? '0 : sat24((54'(az9_r) <<< 4) + 54'(bz9_r));
  end

  assign out_valid            = out_valid_r;
  assign out_total_reflection = out_tir_r;
  assign out_refracted_x      = out_x_r;
  assign out_refracted_y      = out_y_r;
  assign out_refracted_z      = out_z_r;

  `REFV_ASSERT(a_lat_fwd, ((start && !busy) |-> ##PIPE_LAT out_valid), "result missing")
  `REFV_ASSERT(a_lat_back, (out_valid |-> $past(start && !busy, PIPE_LAT)), "spurious result")
  `REFV_ASSERT(a_tir_zero, ((out_valid && out_total_reflection) |->
    (out_refracted_x == 24'sd0 && out_refracted_y == 24'sd0 && out_refracted_z == 24'sd0)),
    "tir result not zero")
  `REFV_ASSERT_RST(a_rst_clear, (!rst_n |=> !out_valid), "strobe after reset")

endmodule

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// refraction vector bench: directed corner vectors, then random unit-ish
// and raw vectors, each result checked against a fixed-point snell predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import refv_pkg::*;

  localparam int       LAT_CYCLES  = PIPE_LAT;
  localparam longint   CYCLE_LIMIT = 400000;
  localparam longint   ONE_Q28     = 64'sd1 << 28;

  typedef struct {
    logic signed [23:0] rx;
    logic signed [23:0] ry;
    logic signed [23:0] rz;
    logic               tir;
  } refr_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_incident_x = '0, in_incident_y = '0, in_incident_z = '0;
  logic signed [15:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [15:0]        in_index_of_refraction = 16'd4096;
  logic               out_valid;
  logic signed [23:0] out_refracted_x, out_refracted_y, out_refracted_z;
  logic               out_total_reflection;

  refr_t  pending_dirs[$];
  int     n_fail = 0;
  longint n_cycle = 0;
  bit     quiet_stretch = 1'b0;

  refraction_vector_top u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    n_cycle <= n_cycle + 1;
    if (n_cycle >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint rnd_shift(longint v, int s);
    longint t;
    t = v + (64'sd1 << (s - 1));
    return t >>> s;
  endfunction

  function automatic logic [23:0] clip24(longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[23:0];
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic refr_t refract_dir(comp_t ix, comp_t iy, comp_t iz,
                                        comp_t nx, comp_t ny, comp_t nz,
                                        logic [15:0] ior_in);
    longint iv[3], nv[3], ior, cosv, eta, eta2, cos2, es, k, root, t;
    refr_t  r;
    logic [23:0] o[3];
    iv[0] = ix; iv[1] = iy; iv[2] = iz;
    nv[0] = nx; nv[1] = ny; nv[2] = nz;
    ior = ior_in;
    if (ior < IOR_MIN) ior = IOR_MIN;
    cosv = iv[0] * nv[0] + iv[1] * nv[1] + iv[2] * nv[2];
    if (cosv > ONE_Q28) cosv = ONE_Q28;
    if (cosv < -ONE_Q28) cosv = -ONE_Q28;
    if (cosv < 0) begin
      cosv = -cosv;
      eta = (64'sd1 << 36) / ior;
    end else begin
      eta = ior << 12;
      for (int i = 0; i < 3; i++) nv[i] = -nv[i];
    end
    // eta^2 stays below 2^56, no overflow
    eta2 = rnd_shift(eta * eta, 24);
    cos2 = rnd_shift(cosv * cosv, 28);
    es = rnd_shift(eta2 * (ONE_Q28 - cos2), 24);
    k = ONE_Q28 - es;
    if (k < 0) begin
      r.rx = '0; r.ry = '0; r.rz = '0; r.tir = 1'b1;
      return r;
    end
    root = int_sqrt(k);
    t = rnd_shift(eta * cosv, 24) - (root << 14);
    for (int i = 0; i < 3; i++)
      o[i] = clip24(rnd_shift(iv[i] * eta * 16 + nv[i] * t, 28));
    r.rx = o[0]; r.ry = o[1]; r.rz = o[2]; r.tir = 1'b0;
    return r;
  endfunction

  // results are checked on the edge that ends their strobe cycle
  always @(posedge clk) begin
    refr_t e;
    if (rst_n && out_valid) begin
      if (pending_dirs.size() == 0) begin
        $error("result beat with nothing expected");
        n_fail++;
      end else begin
        e = pending_dirs.pop_front();
        if (out_refracted_x !== e.rx) begin
          $error("refracted_x exp %0d got %0d", e.rx, out_refracted_x); n_fail++;
        end
        if (out_refracted_y !== e.ry) begin
          $error("refracted_y exp %0d got %0d", e.ry, out_refracted_y); n_fail++;
        end
        if (out_refracted_z !== e.rz) begin
          $error("refracted_z exp %0d got %0d", e.rz, out_refracted_z); n_fail++;
        end
        if (out_total_reflection !== e.tir) begin
          $error("total_reflection exp %0d got %0d", e.tir, out_total_reflection);
          n_fail++;
        end
      end
    end
  end

  task automatic send_ray(comp_t ix, comp_t iy, comp_t iz,
                          comp_t nx, comp_t ny, comp_t nz, logic [15:0] ior);
    if (!quiet_stretch)
      while ($urandom_range(99) < 11) begin
        start <= 1'b0;
        @(posedge clk);
      end
    start <= 1'b1;
    in_incident_x <= ix; in_incident_y <= iy; in_incident_z <= iz;
    in_normal_x <= nx; in_normal_y <= ny; in_normal_z <= nz;
    in_index_of_refraction <= ior;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_dirs.push_back(refract_dir(ix, iy, iz, nx, ny, nz, ior));
  endtask

  task automatic test_corners();
    send_ray(16384, 0, 0, -16384, 0, 0, 16'd4096);
    send_ray(16384, 0, 0, 16384, 0, 0, 16'd6144);
    send_ray(0, -16384, 0, 0, 16384, 0, 16'd6144);
    send_ray(16384, 0, 0, 0, 16384, 0, 16'd65535);      // leaving, total reflection
    send_ray(11585, -11585, 0, 0, 16384, 0, 16'd6144);
    send_ray(11585, 11585, 0, 0, -16384, 0, 16'd6144);
    send_ray(-32768, -32768, -32768, -32768, -32768, -32768, 16'hFFFF);
    send_ray(32767, 32767, 32767, -32768, -32768, -32768, 16'hFFFF);
    send_ray(32767, 32767, 32767, 32767, 32767, 32767, 16'd0);  // ior below one
    send_ray(-32768, 32767, -1, 1, -1, 32767, 16'd4095);
    send_ray(16384, 0, 0, 0, 16384, 0, 16'd4096);       // grazing, k zero
    send_ray(0, 0, 0, 0, 0, 0, 16'd0);
    send_ray(16384, 0, 0, 0, 0, -16384, 16'd8192);
    send_ray(-1, -1, -1, 1, 1, 1, 16'h8000);
  endtask

  task automatic test_random(int n);
    comp_t c[6];
    logic [15:0] ior;
    for (int j = 0; j < n; j++) begin
      quiet_stretch = (j >= n / 2) && (j < n / 2 + 150);
      for (int i = 0; i < 6; i++)
        c[i] = ($urandom_range(3) == 0) ? comp_t'($urandom)
                                         : comp_t'($signed($urandom_range(32768)) - 16384);
      case ($urandom_range(3))
        0:       ior = 16'($urandom);
        1:       ior = 16'($urandom_range(4096));
        default: ior = 16'($urandom_range(4096, 12288));
      endcase
      send_ray(c[0], c[1], c[2], c[3], c[4], c[5], ior);
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_random(1000);
    start <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
